@@ sv/dsfe_pkg.sv @@
// Shared types, codes and constants of the DLE stuffed frame encoder.
package dsfe_pkg;

  localparam int unsigned LenW = 10;

  localparam logic [7:0] StartReset = 8'h02;
  localparam logic [7:0] EscapeReset = 8'h10;
  localparam logic [7:0] EndReset = 8'h03;
  localparam logic [2:0] ChkBytesReset = 3'd1;
  localparam logic [7:0] AsciiZero = 8'h30;

  localparam logic [1:0] StatusOk = 2'd0;
  localparam logic [1:0] StatusOverflow = 2'd1;
  localparam logic [1:0] StatusTooLong = 2'd2;

  typedef enum logic [2:0] {
    CFG_START_CODE     = 3'd0,
    CFG_ESCAPE_CODE    = 3'd1,
    CFG_END_CODE       = 3'd2,
    CFG_STRING_MODE    = 3'd3,
    CFG_CHECKSUM_BYTES = 3'd4
  } cfg_idx_e;

  typedef enum logic [3:0] {
    EM_STX  = 4'd0,
    EM_ID   = 4'd1,
    EM_DLC  = 4'd2,
    EM_DATA = 4'd3,
    EM_CHK  = 4'd4,
    EM_ETX  = 4'd5,
    EM_NUL  = 4'd6,
    EM_OVF  = 4'd7,
    EM_LONG = 4'd8
  } emit_sel_e;

  typedef struct packed {
    logic      load;
    logic      start_end;
    logic      scan_step;
    logic      calc_chk;
    logic      calc_len;
    logic      idx_inc;
    logic      idx_clr;
    logic      ck_dec;
    logic      emit;
    emit_sel_e sel;
    logic      clear_msg;
  } dsfe_cmd_t;

  typedef struct packed {
    logic too_long;
    logic count_zero;
    logic idx_last;
    logic ck_zero;
    logic overflow;
    logic string_mode;
    logic stuffed_done;
    logic out_ok;
  } dsfe_sts_t;

  function automatic logic is_special(input logic [7:0] b, input logic [7:0] stx,
                                      input logic [7:0] dle, input logic [7:0] etx);
    is_special = (b == stx) || (b == dle) || (b == etx);
  endfunction

endpackage

@@ sv/dsfe_ctrl.sv @@
// Controller state machine: sequences loading, length scan and frame emission.
module dsfe_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_kind_i,
  output logic              in_ready_o,
  input  dsfe_pkg::dsfe_sts_t sts_i,
  output dsfe_pkg::dsfe_cmd_t cmd_o
);

  typedef enum logic [12:0] {
    S_IDLE   = 13'h0001,
    S_SCAN   = 13'h0002,
    S_CHK    = 13'h0004,
    S_LEN    = 13'h0008,
    S_DECIDE = 13'h0010,
    S_STX    = 13'h0020,
    S_ID     = 13'h0040,
    S_DLC    = 13'h0080,
    S_DATA   = 13'h0100,
    S_CKS    = 13'h0200,
    S_ETX    = 13'h0400,
    S_NUL    = 13'h0800,
    S_ERR    = 13'h1000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    cmd_o.sel = dsfe_pkg::EM_STX;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (!in_kind_i) begin
            cmd_o.load = 1'b1;
          end else begin
            cmd_o.start_end = 1'b1;
            if (sts_i.too_long) begin
              state_d = S_ERR;
            end else if (sts_i.count_zero) begin
              state_d = S_CHK;
            end else begin
              state_d = S_SCAN;
            end
          end
        end
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.idx_last) begin
          cmd_o.idx_clr = 1'b1;
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        cmd_o.calc_chk = 1'b1;
        state_d = S_LEN;
      end
      S_LEN: begin
        cmd_o.calc_len = 1'b1;
        state_d = S_DECIDE;
      end
      S_DECIDE: begin
        if (!sts_i.overflow) begin
          state_d = S_STX;
        end else if (sts_i.out_ok) begin
          cmd_o.emit = 1'b1;
          cmd_o.sel = dsfe_pkg::EM_OVF;
          cmd_o.clear_msg = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_STX: begin
        cmd_o.sel = dsfe_pkg::EM_STX;
        if (sts_i.out_ok) begin
          cmd_o.emit = 1'b1;
          state_d = S_ID;
        end
      end
      S_ID: begin
        cmd_o.sel = dsfe_pkg::EM_ID;
        if (sts_i.out_ok) begin
          cmd_o.emit = 1'b1;
          state_d = S_DLC;
        end
      end
      S_DLC: begin
        cmd_o.sel = dsfe_pkg::EM_DLC;
        if (sts_i.out_ok) begin
          cmd_o.emit = 1'b1;
          state_d = sts_i.count_zero ? S_CKS : S_DATA;
        end
      end
      S_DATA: begin
        cmd_o.sel = dsfe_pkg::EM_DATA;
        if (sts_i.out_ok) begin
          cmd_o.emit = 1'b1;
          if (sts_i.stuffed_done) begin
            if (sts_i.idx_last) begin
              state_d = S_CKS;
            end else begin
              cmd_o.idx_inc = 1'b1;
            end
          end
        end
      end
      S_CKS: begin
        cmd_o.sel = dsfe_pkg::EM_CHK;
        if (sts_i.out_ok) begin
          cmd_o.emit = 1'b1;
          if (sts_i.stuffed_done) begin
            if (sts_i.ck_zero) begin
              state_d = S_ETX;
            end else begin
              cmd_o.ck_dec = 1'b1;
            end
          end
        end
      end
      S_ETX: begin
        cmd_o.sel = dsfe_pkg::EM_ETX;
        if (sts_i.out_ok) begin
          cmd_o.emit = 1'b1;
          if (sts_i.string_mode) begin
            state_d = S_NUL;
          end else begin
            cmd_o.clear_msg = 1'b1;
            state_d = S_IDLE;
          end
        end
      end
      S_NUL: begin
        cmd_o.sel = dsfe_pkg::EM_NUL;
        if (sts_i.out_ok) begin
          cmd_o.emit = 1'b1;
          cmd_o.clear_msg = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_ERR: begin
        cmd_o.sel = dsfe_pkg::EM_LONG;
        if (sts_i.out_ok) begin
          cmd_o.emit = 1'b1;
          cmd_o.clear_msg = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ sv/dsfe_dp.sv @@
// Datapath: configuration, payload store, checksum and length, byte stuffing, output register.
module dsfe_dp #(
  parameter int unsigned MaxPayload = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic [2:0]          cfg_index_i,
  input  logic [7:0]          cfg_data_i,
  input  logic [7:0]          in_byte_i,
  input  logic [7:0]          in_id_i,
  input  logic [15:0]         in_bound_i,
  input  dsfe_pkg::dsfe_cmd_t cmd_i,
  output dsfe_pkg::dsfe_sts_t sts_o,
  output logic                m_tvalid_o,
  input  logic                m_tready_i,
  output logic [39:0]         m_tdata_o,
  output logic [2:0]          m_tuser_o,
  output logic                m_tlast_o
);

  localparam int unsigned CntW = $clog2(MaxPayload + 1);
  localparam int unsigned IdxW = (MaxPayload > 1) ? $clog2(MaxPayload) : 1;
  localparam int unsigned SumW = CntW + 8;
  localparam int unsigned LenW = dsfe_pkg::LenW;

  logic [7:0] start_q, escape_q, end_q;
  logic       string_q;
  logic [2:0] chk_cfg_q;

  logic [7:0]      store_q [MaxPayload];
  logic [CntW-1:0] count_q;
  logic            too_long_q;
  logic [IdxW-1:0] idx_q;
  logic [SumW-1:0] sum_q;
  logic [CntW-1:0] esc_q;
  logic [31:0]     neg_q;
  logic [1:0]      ck_q;
  logic [LenW-1:0] total_q;
  logic [7:0]      id_q;
  logic [15:0]     bound_q;
  logic            esc_sent_q;

  logic            out_valid_q;
  logic [7:0]      out_fb_q, out_th_q, out_tl_q;
  logic            out_term_q, out_last_q;
  logic [1:0]      out_status_q;
  logic [LenW-1:0] out_len_q;

  logic            full;
  logic [2:0]      cb;
  logic [1:0]      cbm1;
  logic [7:0]      cur_byte;
  logic [7:0]      tx_byte;
  logic            stuff_needed;
  logic [2:0]      chk_esc;
  logic [LenW-1:0] frame_n;
  logic [LenW-1:0] total_d;
  logic            out_ok;

  logic [7:0]      fb_d, th_d, tl_d;
  logic            term_d, last_d;
  logic [1:0]      status_d;
  logic [LenW-1:0] len_d;

  // Checksum size register: zero acts as one byte, anything above four as four.
  always_comb begin
    if (chk_cfg_q == 3'd0) begin
      cb = 3'd1;
    end else if (chk_cfg_q > 3'd4) begin
      cb = 3'd4;
    end else begin
      cb = chk_cfg_q;
    end
  end
  assign cbm1 = 2'(cb - 3'd1);

  assign full = (count_q == CntW'(MaxPayload));
  assign out_ok = !out_valid_q || m_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q   <= dsfe_pkg::StartReset;
      escape_q  <= dsfe_pkg::EscapeReset;
      end_q     <= dsfe_pkg::EndReset;
      string_q  <= 1'b0;
      chk_cfg_q <= dsfe_pkg::ChkBytesReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        dsfe_pkg::CFG_START_CODE:     start_q <= cfg_data_i;
        dsfe_pkg::CFG_ESCAPE_CODE:    escape_q <= cfg_data_i;
        dsfe_pkg::CFG_END_CODE:       end_q <= cfg_data_i;
        dsfe_pkg::CFG_STRING_MODE:    string_q <= cfg_data_i[0];
        dsfe_pkg::CFG_CHECKSUM_BYTES: chk_cfg_q <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && !full) begin
      store_q[count_q[IdxW-1:0]] <= in_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      too_long_q <= 1'b0;
    end else if (cmd_i.clear_msg) begin
      count_q    <= '0;
      too_long_q <= 1'b0;
    end else if (cmd_i.load) begin
      if (full) begin
        too_long_q <= 1'b1;
      end else begin
        count_q <= count_q + CntW'(1);
      end
    end
  end

  // Byte selection for the byte in flight; where stuffing is needed the escape goes out first, then the byte.
  always_comb begin
    unique case (cmd_i.sel)
      dsfe_pkg::EM_STX:  cur_byte = start_q;
      dsfe_pkg::EM_ID:   cur_byte = id_q;
      dsfe_pkg::EM_DLC:  cur_byte = {cbm1, 6'(count_q)};
      dsfe_pkg::EM_DATA: cur_byte = store_q[idx_q];
      dsfe_pkg::EM_CHK:  cur_byte = neg_q[{ck_q, 3'b000} +: 8];
      dsfe_pkg::EM_ETX:  cur_byte = end_q;
      default:           cur_byte = 8'h00;
    endcase
  end

  assign stuff_needed = ((cmd_i.sel == dsfe_pkg::EM_DATA) || (cmd_i.sel == dsfe_pkg::EM_CHK))
                        && dsfe_pkg::is_special(cur_byte, start_q, escape_q, end_q)
                        && !esc_sent_q;
  assign tx_byte = stuff_needed ? escape_q : cur_byte;

  always_comb begin
    chk_esc = 3'd0;
    for (int k = 0; k < 4; k++) begin
      if ((3'(k) < cb) && dsfe_pkg::is_special(neg_q[8*k +: 8], start_q, escape_q, end_q)) begin
        chk_esc = chk_esc + 3'd1;
      end
    end
    frame_n = LenW'(4) + LenW'(count_q) + LenW'(esc_q) + LenW'(cb) + LenW'(chk_esc);
    total_d = string_q ? {frame_n[LenW-2:0], 1'b1} : frame_n;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_end) begin
      id_q    <= in_id_i;
      bound_q <= in_bound_i;
      sum_q   <= '0;
      esc_q   <= '0;
    end else if (cmd_i.scan_step) begin
      sum_q <= sum_q + SumW'(store_q[idx_q]);
      if (dsfe_pkg::is_special(store_q[idx_q], start_q, escape_q, end_q)) begin
        esc_q <= esc_q + CntW'(1);
      end
    end
    if (cmd_i.calc_chk) begin
      neg_q <= ~32'(sum_q) + 32'd1;
    end
    if (cmd_i.calc_chk) begin
      ck_q <= cbm1;
    end else if (cmd_i.ck_dec) begin
      ck_q <= ck_q - 2'd1;
    end
    if (cmd_i.calc_len) begin
      total_q <= total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_end || cmd_i.idx_clr) begin
      idx_q <= '0;
    end else if (cmd_i.scan_step || cmd_i.idx_inc) begin
      idx_q <= idx_q + IdxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_sent_q <= 1'b0;
    end else if (cmd_i.emit) begin
      esc_sent_q <= stuff_needed;
    end
  end

  always_comb begin
    fb_d     = 8'h00;
    th_d     = 8'h00;
    tl_d     = 8'h00;
    term_d   = 1'b0;
    status_d = dsfe_pkg::StatusOk;
    len_d    = '0;
    last_d   = 1'b0;
    unique case (cmd_i.sel)
      dsfe_pkg::EM_OVF: begin
        status_d = dsfe_pkg::StatusOverflow;
        len_d    = total_q;
        last_d   = 1'b1;
      end
      dsfe_pkg::EM_LONG: begin
        status_d = dsfe_pkg::StatusTooLong;
        last_d   = 1'b1;
      end
      dsfe_pkg::EM_NUL: begin
        term_d = 1'b1;
        len_d  = total_q;
        last_d = 1'b1;
      end
      default: begin
        fb_d = tx_byte;
        if (string_q) begin
          th_d = {4'h0, tx_byte[7:4]} + dsfe_pkg::AsciiZero;
          tl_d = {4'h0, tx_byte[3:0]} + dsfe_pkg::AsciiZero;
        end else if (cmd_i.sel == dsfe_pkg::EM_ETX) begin
          len_d  = total_q;
          last_d = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_fb_q     <= fb_d;
      out_th_q     <= th_d;
      out_tl_q     <= tl_d;
      out_term_q   <= term_d;
      out_status_q <= status_d;
      out_len_q    <= len_d;
      out_last_q   <= last_d;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {6'b0, out_len_q, out_tl_q, out_th_q, out_fb_q};
  assign m_tuser_o  = {out_status_q, out_term_q};
  assign m_tlast_o  = out_last_q;

  assign sts_o.too_long     = too_long_q;
  assign sts_o.count_zero   = (count_q == '0);
  assign sts_o.idx_last     = ((CntW'(idx_q) + CntW'(1)) == count_q);
  assign sts_o.ck_zero      = (ck_q == 2'd0);
  assign sts_o.overflow     = ({6'b0, total_q} >= bound_q);
  assign sts_o.string_mode  = string_q;
  assign sts_o.stuffed_done = !stuff_needed;
  assign sts_o.out_ok       = out_ok;

endmodule

@@ sv/dle_stuffed_frame_encoder.sv @@
// Top level of the DLE stuffed frame encoder: controller plus datapath.
//
// Payload bytes (tuser 0) are taken one per cycle while idle into a store of
// MAX_PAYLOAD entries; an end item (tuser 1) is then turned into STX, ID, DLC, the
// stuffed payload, the stuffed negated-sum checksum and ETX, or into a single error
// result. An end item occupies the block for a length scan (each stored byte in turn
// through the single store read port, then checksum and length), plus its results
// while the output side takes them; in string mode each frame byte is one result
// carrying both characters, and the frame is followed by a NUL result. No input is
// taken while a frame is in progress, but loads are taken while the last result
// still waits in the output register. Configuration writes are always taken.
module dle_stuffed_frame_encoder #(
  parameter int unsigned MAX_PAYLOAD = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // Fields from bit 0: data_byte[7:0], msg_id[15:8], bound_limit[31:16].
  input  logic [31:0] s_axis_tdata,
  // Fields from bit 0: kind[0].
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // Fields from bit 0: frame_byte[7:0], text_high[15:8], text_low[23:16],
  // encoded_length[33:24], zero fill[39:34].
  output logic [39:0] m_axis_tdata,
  // Fields from bit 0: is_terminator[0], status[2:1].
  output logic [2:0]  m_axis_tuser,
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  dsfe_pkg::dsfe_cmd_t cmd;
  dsfe_pkg::dsfe_sts_t sts;

  assign cfg_ready_o = 1'b1;

  dsfe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_kind_i  (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dsfe_dp #(
    .MaxPayload (MAX_PAYLOAD)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_byte_i   (s_axis_tdata[7:0]),
    .in_id_i     (s_axis_tdata[15:8]),
    .in_bound_i  (s_axis_tdata[31:16]),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .m_tvalid_o  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_o   (m_axis_tdata),
    .m_tuser_o   (m_axis_tuser),
    .m_tlast_o   (m_axis_tlast)
  );

endmodule
